FILE: hdl/rmth_pkg.sv
// ============================================================================
// rmth_pkg
// Shared types, constants and class functions of the run/magnitude token
// histogram.
// ============================================================================
`default_nettype none

package rmth_pkg;

    // histogram geometry
    localparam int unsigned NUM_BINS = 160;
    localparam int unsigned BIN_W    = 8;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned RCLS_N   = 10;
    localparam int unsigned MCLS_N   = 16;

    localparam logic [BIN_W-1:0] LONG_RUN_BIN = 8'd144;
    localparam logic [7:0]       CHUNK        = 8'd255;
    localparam logic [10:0]      MAG_CLAMP    = 11'd2047;

    // class start points
    localparam logic [7:0] RUN_CLASS_START [RCLS_N] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128
    };
    localparam logic [10:0] MAG_CLASS_START [MCLS_N] = '{
        11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd7,
        11'd8, 11'd16, 11'd32, 11'd64, 11'd128, 11'd256, 11'd512, 11'd1024
    };

    // item commands
    typedef enum logic [1:0] {
        CMD_COEFF = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic acc;
        logic load_zero;
        logic div_start;
        logic rd_long;
        logic wr_long;
        logic rd_tok;
        logic wr_tok;
        logic rd_bin;
        logic cap_bin;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_trivial;
        logic out_free;
        logic is_read;
        logic need_div;
        logic div_done;
        logic tok_needed;
    } t_dp_stat;

    // run class of a run of 0..255
    function automatic logic [3:0] run_class(input logic [7:0] run);
        logic [3:0] cls;
        cls = 4'd0;
        for (int c = 1; c < RCLS_N; c++) begin
            if (run >= RUN_CLASS_START[c]) begin
                cls = 4'(c);
            end
        end
        return cls;
    endfunction

    // magnitude class of a clamped magnitude
    function automatic logic [3:0] mag_class(input logic [10:0] mag);
        logic [3:0] cls;
        cls = 4'd0;
        for (int c = 1; c < MCLS_N; c++) begin
            if (mag >= MAG_CLASS_START[c]) begin
                cls = 4'(c);
            end
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rmth_if.sv
// ============================================================================
// rmth_if
// Valid/ready channels of the token histogram: item in, result out.
// ============================================================================
`default_nettype none

interface rmth_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] coeff_value;
    logic [7:0]         bin_index;

    modport source (output valid, output cmd, output coeff_value, output bin_index,
                    input ready);
    modport sink   (input valid, input cmd, input coeff_value, input bin_index,
                    output ready);
endinterface

interface rmth_out_if;
    logic        valid;
    logic        ready;
    logic        token_counted;
    logic [3:0]  token_run_class;
    logic [3:0]  token_mag_class;
    logic [16:0] long_run_tokens;
    logic [15:0] bin_count;

    modport source (output valid, output token_counted, output token_run_class,
                    output token_mag_class, output long_run_tokens, output bin_count,
                    input ready);
    modport sink   (input valid, input token_counted, input token_run_class,
                    input token_mag_class, input long_run_tokens, input bin_count,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/rmth_ram.sv
// ============================================================================
// rmth_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module rmth_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 160
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/rmth_div255.sv
// ============================================================================
// rmth_div255
// Divide by 255 in three register stages: shifted-sum quotient estimate,
// remainder of the estimate, then a small compare-and-subtract correction.
// ============================================================================
`default_nettype none

module rmth_div255 #(
    parameter int unsigned W = 24
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire [W-1:0]   i_dividend,
    output logic          o_done,
    output logic [W-1:0]  o_quot,
    output logic [7:0]    o_rem
);
    import rmth_pkg::*;

    localparam int unsigned   XW     = (W > 11) ? W : 11;
    localparam logic [XW-1:0] REM_X1 = XW'(CHUNK);
    localparam logic [XW-1:0] REM_X2 = XW'(2 * CHUNK);
    localparam logic [XW-1:0] REM_X3 = XW'(3 * CHUNK);
    localparam logic [XW-1:0] REM_X4 = XW'(4 * CHUNK);

    logic [1:0]    r_cnt;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_q0;
    logic [XW-1:0] r_r0;
    logic [W-1:0]  r_quot;
    logic [7:0]    r_rem;
    logic [W-1:0]  w_q0;
    logic [2:0]    w_fix;
    logic [7:0]    w_rem_fix;

    // estimate x/256 + x/65536 + ..., each term rounded down; never too high
    always_comb begin
        w_q0 = '0;
        for (int s = 8; s < W; s += 8) begin
            w_q0 = w_q0 + (r_x >> s);
        end
    end

    // estimate is low by at most four: fold the excess back out of the remainder
    always_comb begin
        if (r_r0 >= REM_X4) begin
            w_fix     = 3'd4;
            w_rem_fix = 8'(r_r0 - REM_X4);
        end else if (r_r0 >= REM_X3) begin
            w_fix     = 3'd3;
            w_rem_fix = 8'(r_r0 - REM_X3);
        end else if (r_r0 >= REM_X2) begin
            w_fix     = 3'd2;
            w_rem_fix = 8'(r_r0 - REM_X2);
        end else if (r_r0 >= REM_X1) begin
            w_fix     = 3'd1;
            w_rem_fix = 8'(r_r0 - REM_X1);
        end else begin
            w_fix     = 3'd0;
            w_rem_fix = r_r0[7:0];
        end
    end

    // stage counter: 3 estimate, 2 remainder, 1 correction, 0 done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 2'd3;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_cnt == 2'd3) begin
            r_q0 <= w_q0;
        end
        if (r_cnt == 2'd2) begin
            r_r0 <= XW'(r_x) - XW'({r_q0, 8'd0}) + XW'(r_q0);
        end
        if (r_cnt == 2'd1) begin
            r_quot <= r_q0 + W'(w_fix);
            r_rem  <= w_rem_fix;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: hdl/rmth_datapath.sv
// ============================================================================
// rmth_datapath
// Run counter, item registers, histogram store with valid bits, divider and
// result register.
// ============================================================================
`default_nettype none

module rmth_datapath #(
    parameter int unsigned RUN_COUNTER_BITS = 24
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  rmth_pkg::t_dp_cmd        i_cmd,
    output rmth_pkg::t_dp_stat       o_stat,
    input  wire [1:0]                i_in_cmd,
    input  wire signed [31:0]        i_coeff_value,
    input  wire [7:0]                i_bin_index,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic                     o_token_counted,
    output logic [3:0]               o_token_run_class,
    output logic [3:0]               o_token_mag_class,
    output logic [16:0]              o_long_run_tokens,
    output logic [15:0]              o_bin_count
);
    import rmth_pkg::*;

    localparam int unsigned RW = RUN_COUNTER_BITS;
    localparam int unsigned QW = (RW > 17) ? RW : 17;
    localparam logic [RW-1:0] RUN_255 = RW'(255);
    localparam logic [RW-1:0] RUN_256 = RW'(256);

    // zero run and item registers
    logic [RW-1:0]       r_run;
    t_cmd                r_cmd;
    logic                r_trivial;
    logic                r_need_div;
    logic [RW-1:0]       r_dvd;
    logic [7:0]          r_run_lo;
    logic [3:0]          r_mcls;
    logic [BIN_W-1:0]    r_bin_idx;
    logic [CNT_W-1:0]    r_bcount;

    // store
    logic [NUM_BINS-1:0] r_valid;
    logic                r_rd_ok;
    logic [CNT_W-1:0]    w_rdata;
    logic [BIN_W-1:0]    w_addr;
    logic                w_we;
    logic [CNT_W-1:0]    w_wdata;
    logic [CNT_W-1:0]    w_base;

    // decode of the offered item
    t_cmd                w_in_cmd;
    logic                w_coef_zero;
    logic                w_need_div_in;
    logic [31:0]         w_abs;
    logic [10:0]         w_mag;

    // divider and token
    logic                w_div_done;
    logic [RW-1:0]       w_quot;
    logic [7:0]          w_rem;
    logic [QW-1:0]       w_q_ext;
    logic [7:0]          w_tokrun;
    logic [3:0]          w_rcls;
    logic                w_counted;

    assign w_in_cmd    = t_cmd'(i_in_cmd);
    assign w_coef_zero = (i_coeff_value == 32'sd0);
    assign w_abs       = i_coeff_value[31] ? (~i_coeff_value + 32'd1) : i_coeff_value;
    assign w_mag       = (w_abs > 32'(MAG_CLAMP)) ? MAG_CLAMP : w_abs[10:0];

    assign w_need_div_in = ((w_in_cmd == CMD_COEFF) && !w_coef_zero && (r_run >= RUN_256))
                        || ((w_in_cmd == CMD_FLUSH) && (r_run >= RUN_255));

    // items whose result is all zeros and need no store access
    assign o_stat.in_trivial = ((w_in_cmd == CMD_COEFF) && w_coef_zero)
                            || (w_in_cmd == CMD_CLEAR)
                            || ((w_in_cmd == CMD_FLUSH) && (r_run == '0))
                            || ((w_in_cmd == CMD_READ) && (i_bin_index >= BIN_W'(NUM_BINS)));

    // run counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_cmd.acc) begin
            if (w_in_cmd == CMD_COEFF && w_coef_zero) begin
                if (r_run != '1) begin
                    r_run <= r_run + RW'(1);
                end
            end else if (w_in_cmd == CMD_COEFF || w_in_cmd == CMD_FLUSH) begin
                r_run <= '0;
            end
        end
    end

    // latch the item at transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_cmd      <= w_in_cmd;
            r_trivial  <= o_stat.in_trivial;
            r_need_div <= w_need_div_in;
            r_dvd      <= (w_in_cmd == CMD_COEFF) ? (r_run - RW'(1)) : r_run;
            r_run_lo   <= r_run[7:0];
            r_mcls     <= (w_in_cmd == CMD_COEFF) ? mag_class(w_mag) : 4'd0;
            r_bin_idx  <= i_bin_index;
        end
    end

    rmth_div255 #(
        .W (RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_dvd),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // token run after long-run tokens are taken off
    assign w_q_ext  = QW'(w_quot);
    assign w_tokrun = r_need_div ? ((r_cmd == CMD_COEFF) ? (w_rem + 8'd1) : w_rem) : r_run_lo;
    assign w_rcls   = run_class(w_tokrun);

    // store address and write data
    always_comb begin
        if (i_cmd.rd_long || i_cmd.wr_long) begin
            w_addr = LONG_RUN_BIN;
        end else if (i_cmd.rd_tok || i_cmd.wr_tok) begin
            w_addr = {w_rcls, r_mcls};
        end else begin
            w_addr = r_bin_idx;
        end
    end

    assign w_we    = i_cmd.wr_long || i_cmd.wr_tok;
    assign w_base  = r_rd_ok ? w_rdata : '0;
    assign w_wdata = w_base + (i_cmd.wr_long ? w_q_ext[CNT_W-1:0] : CNT_W'(1));

    rmth_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // valid bits: a bin never written since reset or clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.acc && w_in_cmd == CMD_CLEAR) begin
                r_valid <= '0;
            end
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_long || i_cmd.rd_tok || i_cmd.rd_bin) begin
            r_rd_ok <= r_valid[w_addr];
        end
        if (i_cmd.cap_bin) begin
            r_bcount <= w_base;
        end
    end

    assign w_counted = !r_trivial
                    && ((r_cmd == CMD_COEFF) || ((r_cmd == CMD_FLUSH) && (w_tokrun != 8'd0)));

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_zero || i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_zero) begin
            o_token_counted   <= 1'b0;
            o_token_run_class <= '0;
            o_token_mag_class <= '0;
            o_long_run_tokens <= '0;
            o_bin_count       <= '0;
        end else if (i_cmd.load_out) begin
            o_token_counted   <= w_counted;
            o_token_run_class <= w_counted ? w_rcls : 4'd0;
            o_token_mag_class <= w_counted ? r_mcls : 4'd0;
            o_long_run_tokens <= (!r_trivial && r_need_div) ? w_q_ext[16:0] : 17'd0;
            o_bin_count       <= (!r_trivial && r_cmd == CMD_READ) ? r_bcount : '0;
        end
    end

    assign o_stat.out_free   = !o_out_valid || i_out_ready;
    assign o_stat.is_read    = (r_cmd == CMD_READ);
    assign o_stat.need_div   = r_need_div;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.tok_needed = (r_cmd == CMD_COEFF) || (w_tokrun != 8'd0);

endmodule

`default_nettype wire

FILE: hdl/rmth_ctrl.sv
// ============================================================================
// rmth_ctrl
// Sequencer of the token histogram: divide, read-modify-write steps and
// result hand-off.
// ============================================================================
`default_nettype none

module rmth_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  rmth_pkg::t_dp_stat   i_stat,
    output rmth_pkg::t_dp_cmd    o_cmd
);
    import rmth_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_RD_LONG,
        S_WR_LONG,
        S_RD_TOK,
        S_WR_TOK,
        S_RD_BIN,
        S_CAP_BIN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.acc = w_acc;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_stat.in_trivial) begin
                        if (i_stat.out_free) begin
                            o_cmd.load_zero = 1'b1;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_stat.is_read) begin
                    n_state = S_RD_BIN;
                end else if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_RD_TOK;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_RD_LONG;
                end
            end
            S_RD_LONG: begin
                o_cmd.rd_long = 1'b1;
                n_state = S_WR_LONG;
            end
            S_WR_LONG: begin
                o_cmd.wr_long = 1'b1;
                n_state = i_stat.tok_needed ? S_RD_TOK : S_FIN;
            end
            S_RD_TOK: begin
                o_cmd.rd_tok = 1'b1;
                n_state = S_WR_TOK;
            end
            S_WR_TOK: begin
                o_cmd.wr_tok = 1'b1;
                n_state = S_FIN;
            end
            S_RD_BIN: begin
                o_cmd.rd_bin = 1'b1;
                n_state = S_CAP_BIN;
            end
            S_CAP_BIN: begin
                o_cmd.cap_bin = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/run_magnitude_token_histogram_core.sv
// ============================================================================
// run_magnitude_token_histogram_core
// Zero-run / magnitude-class token histogram of one wavelet band, 160 bins.
// ============================================================================
//
//  channel   dir  modport           payload
//  i_in      in   rmth_in_if.sink   cmd, coeff_value, bin_index
//  o_out     out  rmth_out_if.source token_counted, token_run_class,
//                                   token_mag_class, long_run_tokens, bin_count
//
// Steps: zero coefficient, clear, empty flush and out-of-range read need no store
// access; a read reads its bin once and a nonzero coefficient with a short run
// makes one read-modify-write on the simple dual-port bin store. A run of 256
// or more (flush: 255 or more) adds the three-stage divide by 255 and a second
// read-modify-write on the long-run bin; a flush of an exact multiple of 255 skips the token one.
// Reset: bin valid bits and the run counter clear at once; no sweep.
// Stalls: a held result sits in the output register; the next item is taken
// while it waits and stops at its own hand-off until the register frees.
// ============================================================================
`default_nettype none

module run_magnitude_token_histogram_core #(
    parameter int unsigned RUN_COUNTER_BITS = 24
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    rmth_in_if.sink      i_in,
    rmth_out_if.source   o_out
);
    import rmth_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    rmth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rmth_datapath #(
        .RUN_COUNTER_BITS (RUN_COUNTER_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_in_cmd          (i_in.cmd),
        .i_coeff_value     (i_in.coeff_value),
        .i_bin_index       (i_in.bin_index),
        .o_out_valid       (w_out_valid),
        .i_out_ready       (o_out.ready),
        .o_token_counted   (o_out.token_counted),
        .o_token_run_class (o_out.token_run_class),
        .o_token_mag_class (o_out.token_mag_class),
        .o_long_run_tokens (o_out.long_run_tokens),
        .o_bin_count       (o_out.bin_count)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // divider only starts for runs long enough to need it
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> w_stat.need_div)
        else $error("divider started without a long run");

    // every bin write comes in the cycle right after its read
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_long || w_cmd.wr_tok) |-> $past(w_cmd.rd_long || w_cmd.rd_tok))
        else $error("bin write without preceding read");

    // a result is never loaded over one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out || w_cmd.load_zero) |-> (!w_out_valid || o_out.ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire
